[src/etp_pkg.sv]
// ----------------------------------------------------------------------------
// etp_pkg
// Shared types and constants of the exclusive time profiler.
// ----------------------------------------------------------------------------
`default_nettype none

package etp_pkg;

    // fixed field widths
    localparam int ID_W   = 6;
    localparam int TIME_W = 32;
    localparam int AMT_W  = TIME_W + 1;
    localparam int CFG_W  = 7;

    // default sizes
    localparam int DEF_MAX_FUNCTIONS = 64;
    localparam int DEF_STACK_DEPTH   = 64;

    // entries in the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // work item handed from front to back
    typedef struct packed {
        logic              credit_en;
        logic [ID_W-1:0]   credit_id;
        logic [AMT_W-1:0]  amount;
        logic              dump;
    } etp_cmd_t;

    typedef enum logic {
        F_IDLE,
        F_REFILL
    } etp_front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_UPDATE,
        B_DUMP_RD,
        B_DUMP_OUT
    } etp_back_state_t;

endpackage

`default_nettype wire

[src/etp_queue.sv]
// ----------------------------------------------------------------------------
// etp_queue
// Short first-in first-out queue of work items between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module etp_queue (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  etp_pkg::etp_cmd_t     push_cmd,
    output logic                  full,
    input  wire logic             pop,
    output etp_pkg::etp_cmd_t     head_cmd,
    output logic                  empty
);

    localparam int PTR_W = (etp_pkg::QUEUE_DEPTH > 1) ? $clog2(etp_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(etp_pkg::QUEUE_DEPTH + 1);

    etp_pkg::etp_cmd_t entry_reg [etp_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full     = (count_reg == CNT_W'(etp_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign head_cmd = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(etp_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(etp_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

[src/etp_front.sv]
// ----------------------------------------------------------------------------
// etp_front
// Takes call events, keeps the call stack and the previous event, and turns
// each event into a credit (function id and amount) plus a dump flag.
// ----------------------------------------------------------------------------
`default_nettype none

module etp_front #(
    parameter int MAX_FUNCTIONS = etp_pkg::DEF_MAX_FUNCTIONS,
    parameter int STACK_DEPTH   = etp_pkg::DEF_STACK_DEPTH
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [etp_pkg::ID_W-1:0]   in_function_id,
    input  wire logic                       in_action,
    input  wire logic [etp_pkg::TIME_W-1:0] in_timestamp,
    input  wire logic                       in_last,
    output logic                            cmd_push,
    output etp_pkg::etp_cmd_t               cmd,
    input  wire logic                       q_full
);

    localparam int LVL_W  = $clog2(STACK_DEPTH + 1);
    localparam int SIDX_W = $clog2(STACK_DEPTH);
    localparam int ID_W   = etp_pkg::ID_W;
    localparam int TIME_W = etp_pkg::TIME_W;
    localparam int DIFF_W = TIME_W + 2;

    etp_pkg::etp_front_state_t state_reg, state_next;
    logic [LVL_W-1:0]  level_reg, level_next;
    logic [ID_W-1:0]   top_reg, top_next;
    logic [ID_W-1:0]   prior_fn_reg, prior_fn_next;
    logic              prior_start_reg, prior_start_next;
    logic [TIME_W-1:0] prior_time_reg, prior_time_next;

    // stack below the top entry
    logic [ID_W-1:0]   stk_mem [STACK_DEPTH];
    logic [ID_W-1:0]   stk_rd_reg;
    logic              stk_we;
    logic [LVL_W-1:0]  level_m1;
    logic [LVL_W-1:0]  level_m2;

    logic              accept;
    logic              ending_self;
    logic [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0] amt;
    logic              amt_pos;
    logic [ID_W-1:0]   credit_id;
    logic              credit_ok;

    assign accept   = in_valid && in_ready;
    assign level_m1 = level_reg - LVL_W'(1);
    assign level_m2 = level_reg - LVL_W'(2);

    // elapsed time with the unit adjustment of the event pair
    assign ending_self = !in_action && prior_start_reg && (in_function_id == prior_fn_reg);
    assign diff = {2'b00, in_timestamp} - {2'b00, prior_time_reg};

    always_comb begin
        if (ending_self) begin
            amt = diff + DIFF_W'(1);
        end else if (in_action && !prior_start_reg) begin
            amt = diff - DIFF_W'(1);
        end else begin
            amt = diff;
        end
    end

    assign amt_pos   = !amt[DIFF_W-1] && (amt != '0);
    assign credit_id = ending_self ? in_function_id : top_reg;
    assign credit_ok = ({1'b0, credit_id} < (ID_W + 1)'(MAX_FUNCTIONS));

    // next state, stack control and command
    always_comb begin
        state_next       = state_reg;
        level_next       = level_reg;
        top_next         = top_reg;
        prior_fn_next    = prior_fn_reg;
        prior_start_next = prior_start_reg;
        prior_time_next  = prior_time_reg;
        stk_we           = 1'b0;
        in_ready         = 1'b0;
        cmd_push         = 1'b0;
        cmd.credit_en    = 1'b0;
        cmd.credit_id    = credit_id;
        cmd.amount       = amt[etp_pkg::AMT_W-1:0];
        cmd.dump         = in_last;

        unique case (state_reg)
            etp_pkg::F_IDLE: begin
                in_ready = !q_full;
                if (accept) begin
                    cmd_push = 1'b1;
                    if (level_reg == '0) begin
                        // empty stack: push, nothing credited
                        top_next   = in_function_id;
                        level_next = LVL_W'(1);
                    end else if (!in_action) begin
                        // end: credit and pop
                        cmd.credit_en = amt_pos && credit_ok;
                        level_next    = level_m1;
                        if (level_m1 != '0) begin
                            state_next = etp_pkg::F_REFILL;
                        end
                    end else begin
                        // start: credit the top and push
                        cmd.credit_en = amt_pos && credit_ok;
                        if (level_reg < LVL_W'(STACK_DEPTH)) begin
                            stk_we     = 1'b1;
                            top_next   = in_function_id;
                            level_next = level_reg + LVL_W'(1);
                        end
                    end
                    prior_fn_next    = in_function_id;
                    prior_start_next = in_action;
                    prior_time_next  = in_timestamp;
                    if (in_last) begin
                        state_next       = etp_pkg::F_IDLE;
                        level_next       = '0;
                        prior_fn_next    = '0;
                        prior_start_next = 1'b0;
                        prior_time_next  = '0;
                    end
                end
            end
            etp_pkg::F_REFILL: begin
                // new top comes back from the stack memory
                top_next   = stk_rd_reg;
                state_next = etp_pkg::F_IDLE;
            end
            default: begin
                state_next = etp_pkg::F_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= etp_pkg::F_IDLE;
            level_reg       <= '0;
            top_reg         <= '0;
            prior_fn_reg    <= '0;
            prior_start_reg <= 1'b0;
            prior_time_reg  <= '0;
        end else begin
            state_reg       <= state_next;
            level_reg       <= level_next;
            top_reg         <= top_next;
            prior_fn_reg    <= prior_fn_next;
            prior_start_reg <= prior_start_next;
            prior_time_reg  <= prior_time_next;
        end
    end

    // stack memory: old top written on push, entry below read for a pop
    always_ff @(posedge aclk) begin
        if (stk_we) begin
            stk_mem[level_m1[SIDX_W-1:0]] <= top_reg;
        end
        stk_rd_reg <= stk_mem[level_m2[SIDX_W-1:0]];
    end

endmodule

`default_nettype wire

[src/etp_back.sv]
// ----------------------------------------------------------------------------
// etp_back
// Holds one exclusive-time total per function, applies credits by
// read-modify-write and streams the totals of the first function_count ids out on a dump.
// ----------------------------------------------------------------------------
`default_nettype none

module etp_back #(
    parameter int MAX_FUNCTIONS = etp_pkg::DEF_MAX_FUNCTIONS
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [etp_pkg::CFG_W-1:0]  cfg_data,
    input  wire logic                       q_empty,
    input  etp_pkg::etp_cmd_t               head_cmd,
    output logic                            q_pop,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [etp_pkg::ID_W-1:0]        out_function,
    output logic [etp_pkg::TIME_W-1:0]      out_time,
    output logic                            out_last
);

    localparam int FID_W  = (MAX_FUNCTIONS > 1) ? $clog2(MAX_FUNCTIONS) : 1;
    localparam int CNT_W  = $clog2(MAX_FUNCTIONS + 1);
    localparam int TIME_W = etp_pkg::TIME_W;
    localparam int SUM_W  = etp_pkg::AMT_W + 1;
    localparam int CFG_W  = etp_pkg::CFG_W;

    etp_pkg::etp_back_state_t state_reg, state_next;
    etp_pkg::etp_cmd_t        cmd_reg, cmd_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [FID_W-1:0]         k_reg, k_next;
    logic [MAX_FUNCTIONS-1:0] tvld_reg, tvld_next;
    logic                     out_valid_reg, out_valid_next;
    logic [etp_pkg::ID_W-1:0] out_function_reg, out_function_next;
    logic [TIME_W-1:0]        out_time_reg, out_time_next;
    logic                     out_last_reg, out_last_next;

    // totals memory
    logic [TIME_W-1:0]        tot_mem [MAX_FUNCTIONS];
    logic [TIME_W-1:0]        tot_rd_reg;
    logic [FID_W-1:0]         rd_addr;
    logic                     tot_we;
    logic [FID_W-1:0]         cmd_idx;
    logic [TIME_W-1:0]        old_total;
    logic [SUM_W-1:0]         sum;
    logic [TIME_W-1:0]        new_total;
    logic                     slot_free;
    logic                     k_is_last;

    assign cfg_ready    = 1'b1;
    assign out_valid    = out_valid_reg;
    assign out_function = out_function_reg;
    assign out_time     = out_time_reg;
    assign out_last     = out_last_reg;

    assign cmd_idx   = cmd_reg.credit_id[FID_W-1:0];
    assign old_total = tvld_reg[cmd_idx] ? tot_rd_reg : '0;
    assign sum       = {{(SUM_W-TIME_W){1'b0}}, old_total} + {1'b0, cmd_reg.amount};
    assign new_total = (sum[SUM_W-1:TIME_W] != '0) ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
    assign slot_free = !out_valid_reg || out_ready;
    assign k_is_last = ((CNT_W'(k_reg) + CNT_W'(1)) == count_reg);

    // register write, clamped into one to the number of functions
    always_comb begin
        count_next = count_reg;
        if (cfg_valid) begin
            if (cfg_data == '0) begin
                count_next = CNT_W'(1);
            end else if (cfg_data > CFG_W'(MAX_FUNCTIONS)) begin
                count_next = CNT_W'(MAX_FUNCTIONS);
            end else begin
                count_next = CNT_W'(cfg_data);
            end
        end
    end

    // sequencer for credits and dumps
    always_comb begin
        state_next        = state_reg;
        cmd_next          = cmd_reg;
        k_next            = k_reg;
        tvld_next         = tvld_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        out_function_next = out_function_reg;
        out_time_next     = out_time_reg;
        out_last_next     = out_last_reg;
        q_pop             = 1'b0;
        tot_we            = 1'b0;
        rd_addr           = head_cmd.credit_id[FID_W-1:0];

        unique case (state_reg)
            etp_pkg::B_IDLE: begin
                if (!q_empty) begin
                    q_pop    = 1'b1;
                    cmd_next = head_cmd;
                    if (head_cmd.credit_en) begin
                        state_next = etp_pkg::B_UPDATE;
                    end else if (head_cmd.dump) begin
                        state_next = etp_pkg::B_DUMP_RD;
                    end
                end
            end
            etp_pkg::B_UPDATE: begin
                tot_we             = 1'b1;
                tvld_next[cmd_idx] = 1'b1;
                state_next         = cmd_reg.dump ? etp_pkg::B_DUMP_RD : etp_pkg::B_IDLE;
            end
            etp_pkg::B_DUMP_RD: begin
                rd_addr    = k_reg;
                state_next = etp_pkg::B_DUMP_OUT;
            end
            etp_pkg::B_DUMP_OUT: begin
                // keep the read data of this total while the beat waits
                rd_addr = k_reg;
                if (slot_free) begin
                    out_valid_next    = 1'b1;
                    out_function_next = etp_pkg::ID_W'(k_reg);
                    out_time_next     = tvld_reg[k_reg] ? tot_rd_reg : '0;
                    out_last_next     = k_is_last;
                    if (k_is_last) begin
                        k_next     = '0;
                        tvld_next  = '0;
                        state_next = etp_pkg::B_IDLE;
                    end else begin
                        k_next     = k_reg + FID_W'(1);
                        state_next = etp_pkg::B_DUMP_RD;
                    end
                end
            end
            default: begin
                state_next = etp_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= etp_pkg::B_IDLE;
            count_reg     <= CNT_W'(MAX_FUNCTIONS);
            k_reg         <= '0;
            tvld_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            k_reg         <= k_next;
            tvld_reg      <= tvld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        cmd_reg          <= cmd_next;
        out_function_reg <= out_function_next;
        out_time_reg     <= out_time_next;
        out_last_reg     <= out_last_next;
    end

    // totals memory: one write, one registered read
    always_ff @(posedge aclk) begin
        if (tot_we) begin
            tot_mem[cmd_idx] <= new_total;
        end
        tot_rd_reg <= tot_mem[rd_addr];
    end

endmodule

`default_nettype wire

[src/exclusive_time_profiler.sv]
// ----------------------------------------------------------------------------
// exclusive_time_profiler
// Exclusive time per function from a stream of start and end call events.
// ----------------------------------------------------------------------------
// The s_ channel takes one call event per beat: function id and timestamp in
// s_tdata, the action (1 = start, 0 = end) in s_tuser and the final event of
// a log in s_tlast. The front keeps the call stack and works out the credit;
// an end that leaves the stack non-empty also passes through a refill state,
// as the new top is read back from the stack memory. A two-entry queue hands
// each credit to the back, which reads the total in its idle state and writes
// the sum back in its update state, so it takes no new credit before the last
// is written. After the final event the m_ channel gives function_count beats,
// one per function in id order with m_tlast on the last; each total is read
// in a read state and sent in an output state, which waits while the receiver
// is not ready; events keep being taken into the queue meanwhile until it fills.
// A stalled m_ beat holds; the back then waits and the queue fills, which
// drops s_tready. cfg_data (function count) is always ready and is meant to
// be written while the block is idle.
// Reset empties the stack, zeroes all totals and the previous event and
// sets the function count to its maximum; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module exclusive_time_profiler #(
    parameter int MAX_FUNCTIONS = etp_pkg::DEF_MAX_FUNCTIONS,
    parameter int STACK_DEPTH   = etp_pkg::DEF_STACK_DEPTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration write
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [6:0]  cfg_data,     // function_count
    // event input
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,      // function_id[5:0], timestamp[37:6], zero pad
    input  wire logic        s_tuser,      // action
    input  wire logic        s_tlast,      // last_event
    // result output
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,      // result_function[5:0], exclusive_time[37:6], zero pad
    output logic             m_tlast       // last_result
);

    etp_pkg::etp_cmd_t                push_cmd;
    etp_pkg::etp_cmd_t                head_cmd;
    logic                             cmd_push;
    logic                             q_full;
    logic                             q_empty;
    logic                             q_pop;
    logic [etp_pkg::ID_W-1:0]         res_function;
    logic [etp_pkg::TIME_W-1:0]       res_time;

    // front: stack and credit
    etp_front #(
        .MAX_FUNCTIONS (MAX_FUNCTIONS),
        .STACK_DEPTH   (STACK_DEPTH)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .in_function_id (s_tdata[5:0]),
        .in_action      (s_tuser),
        .in_timestamp   (s_tdata[37:6]),
        .in_last        (s_tlast),
        .cmd_push       (cmd_push),
        .cmd            (push_cmd),
        .q_full         (q_full)
    );

    // queue between front and back
    etp_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (cmd_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .empty    (q_empty)
    );

    // back: totals and dump
    etp_back #(
        .MAX_FUNCTIONS (MAX_FUNCTIONS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .q_empty      (q_empty),
        .head_cmd     (head_cmd),
        .q_pop        (q_pop),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_function (res_function),
        .out_time     (res_time),
        .out_last     (m_tlast)
    );

    assign m_tdata = {2'b00, res_time, res_function};

endmodule

`default_nettype wire
